@@ rtl/gdad_pkg.sv @@
package gdad_pkg;

  localparam logic [15:0] YEAR_MAX   = 16'hFFFF;
  localparam int          MOD_STEPS  = 8;    // 400 << 7 is the largest power-of-two multiple of 400 below 2^16
  localparam int          SHIFT_W    = $clog2(MOD_STEPS);
  localparam logic [8:0]  LEAP_CYCLE = 9'd400;
  localparam logic [3:0]  MONTH_JAN  = 4'd1;
  localparam logic [3:0]  MONTH_FEB  = 4'd2;
  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [4:0]  DAY_LAST   = 5'd31;

  typedef enum logic {
    SEL_MOD,
    SEL_WALK
  } sub_sel_e;

  typedef struct packed {
    sub_sel_e             sel;
    logic [SHIFT_W-1:0]   shift;
  } sub_ctrl_t;

  // Month length; codes 0 and 13..15 follow the same alternating pattern.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12, 4'd14: len = 5'd31;
      4'd2:    len = leap ? 5'd29 : 5'd28;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

@@ rtl/gregorian_date_add_days.sv @@
// Gregorian date advance: adds days_to_add_i to a start date, one month per cycle.
// The year is first reduced mod 400 by shift-and-subtract, then the date walks month by month
// and ends with one final compare; done_o pulses the cycle after.
// Throughput: one item at a time; busy is high from acceptance until done_o pulses.
// All time is spent in the shared subtractor. The receiver cannot stall.
// Reset (rst_ni low, async) returns the sequencer to idle and clears done_o.
module gregorian_date_add_days
  import gdad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [15:0] start_year_i,
  input  logic [15:0] days_to_add_i,
  output logic        done_o,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [15:0] result_year_o,
  output logic        year_overflow_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic               done_q, done_d;

  // working item
  logic [16:0] day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [15:0] year_q, year_d;
  logic [15:0] rem_q, rem_d;      // year mod 400 once reduction is done

  // result registers
  logic [4:0]  res_day_q, res_day_d;
  logic [3:0]  res_month_q, res_month_d;
  logic [15:0] res_year_q, res_year_d;
  logic        res_ovf_q, res_ovf_d;

  sub_ctrl_t   sub_ctrl;
  logic [16:0] sub_diff;
  logic        sub_borrow;
  logic        leap;
  logic [4:0]  mlen;
  logic        step;
  logic [4:0]  month_inc;

  assign busy = (state_q != ST_IDLE);

  // Leap: r == 0, or year divisible by 4 and r not a multiple of 100.
  assign leap = (rem_q[8:0] == 9'd0) ||
                ((year_q[1:0] == 2'd0) && (rem_q[8:0] != 9'd100) &&
                 (rem_q[8:0] != 9'd200) && (rem_q[8:0] != 9'd300));
  assign mlen = month_len(month_q, leap && (month_q == MONTH_FEB));

  assign sub_ctrl.sel   = (state_q == ST_MOD) ? SEL_MOD : SEL_WALK;
  assign sub_ctrl.shift = shift_q;

  gdad_sub_unit u_sub (
    .ctrl_i   (sub_ctrl),
    .rem_i    (rem_q),
    .day_i    (day_q),
    .mlen_i   (mlen),
    .diff_o   (sub_diff),
    .borrow_o (sub_borrow)
  );

  // day > month length
  assign step      = !sub_borrow && (sub_diff != 17'd0);
  assign month_inc = {1'b0, month_q} + 5'd1;

  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    done_d      = 1'b0;
    day_d       = day_q;
    month_d     = month_q;
    year_d      = year_q;
    rem_d       = rem_q;
    res_day_d   = res_day_q;
    res_month_d = res_month_q;
    res_year_d  = res_year_q;
    res_ovf_d   = res_ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          day_d   = {12'd0, start_day_i} + {1'b0, days_to_add_i};
          month_d = start_month_i;
          year_d  = start_year_i;
          rem_d   = start_year_i;
          shift_d = SHIFT_W'(MOD_STEPS - 1);
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (!sub_borrow) begin
          rem_d = sub_diff[15:0];
        end
        shift_d = shift_q - 1'b1;
        if (shift_q == '0) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (step) begin
          day_d = sub_diff;
          if (month_inc > {1'b0, MONTH_DEC}) begin
            if (year_q == YEAR_MAX) begin
              // walked past the last representable December: saturate
              res_day_d   = DAY_LAST;
              res_month_d = MONTH_DEC;
              res_year_d  = YEAR_MAX;
              res_ovf_d   = 1'b1;
              done_d      = 1'b1;
              state_d     = ST_IDLE;
            end else begin
              month_d = MONTH_JAN;
              year_d  = year_q + 16'd1;
              rem_d   = (rem_q[8:0] == LEAP_CYCLE - 9'd1) ? 16'd0 : rem_q + 16'd1;
            end
          end else begin
            month_d = month_inc[3:0];
          end
        end else begin
          res_day_d   = day_q[4:0];
          res_month_d = month_q;
          res_year_d  = year_q;
          res_ovf_d   = 1'b0;
          done_d      = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      shift_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      shift_q <= shift_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q       <= day_d;
    month_q     <= month_d;
    year_q      <= year_d;
    rem_q       <= rem_d;
    res_day_q   <= res_day_d;
    res_month_q <= res_month_d;
    res_year_q  <= res_year_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign done_o          = done_q;
  assign result_day_o    = res_day_q;
  assign result_month_o  = res_month_q;
  assign result_year_o   = res_year_q;
  assign year_overflow_o = res_ovf_q;

`ifndef NO_ASSERTIONS
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done_o held longer than one cycle");

  a_done_on_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("sequencer finished without a result");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobed while still busy");

  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && year_overflow_o) |-> (result_year_o == YEAR_MAX &&
      result_month_o == MONTH_DEC && result_day_o == DAY_LAST))
    else $error("overflow result not saturated");

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (rem_q < 16'd400))
    else $error("year remainder out of range");
`endif

endmodule

@@ rtl/gdad_sub_unit.sv @@
module gdad_sub_unit
  import gdad_pkg::*;
(
  input  sub_ctrl_t   ctrl_i,
  input  logic [15:0] rem_i,
  input  logic [16:0] day_i,
  input  logic [4:0]  mlen_i,
  output logic [16:0] diff_o,
  output logic        borrow_o
);

  logic [16:0] op_a;
  logic [16:0] op_b;
  logic [17:0] sum;

  // Shared subtractor: year reduction mod 400, then day minus month length.
  always_comb begin
    case (ctrl_i.sel)
      SEL_MOD: begin
        op_a = {1'b0, rem_i};
        op_b = {8'd0, LEAP_CYCLE} << ctrl_i.shift;
      end
      default: begin
        op_a = day_i;
        op_b = {12'd0, mlen_i};
      end
    endcase
  end

  assign sum      = {1'b0, op_a} - {1'b0, op_b};
  assign diff_o   = sum[16:0];
  assign borrow_o = sum[17];

endmodule
